// ===== hw/rtl/picir_pkg.sv =====
package picir_pkg;

   localparam int ANGLE_W         = 32;
   localparam int ERR_W           = 32;
   localparam int GAIN_W          = 24;
   localparam int LIMIT_W         = 15;
   localparam int THRESH_W        = 31;
   localparam int DRIVE_W         = 16;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 31;

   localparam int ANGLE_FRAC_BITS = 12;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int SUM_FRAC        = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
   localparam int SUM_W           = 64;

   // The integral product magnitude saturates at 2^CAP_LOG.
   localparam int CAP_LOG         = 61;
   localparam int CAP_W           = CAP_LOG + 1;

   // The integral magnitude is multiplied in two slices, the low one LO_W bits wide.
   localparam int LO_W            = 32;

   localparam int INTEGRAL_WIDTH_DEFAULT = 48;
   localparam int NUM_STAGES      = 6;

   localparam logic [GAIN_W-1:0]   PROPORTIONAL_GAIN_RESET = GAIN_W'(128000);
   localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RESET     = GAIN_W'(6400);
   localparam logic [GAIN_W-1:0]   DERIVATIVE_GAIN_RESET   = GAIN_W'(0);
   localparam logic [LIMIT_W-1:0]  OUTPUT_LIMIT_RESET      = LIMIT_W'(4095);
   localparam logic [THRESH_W-1:0] REJECT_THRESHOLD_RESET  = THRESH_W'(409600000);
   localparam logic [THRESH_W-1:0] INTEGRAL_BOUND_RESET    = THRESH_W'(20480);

   typedef enum logic [0:0] {
      OP_UPDATE = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PROPORTIONAL_GAIN = 3'd0,
      REG_INTEGRAL_GAIN     = 3'd1,
      REG_DERIVATIVE_GAIN   = 3'd2,
      REG_OUTPUT_LIMIT      = 3'd3,
      REG_REJECT_THRESHOLD  = 3'd4,
      REG_INTEGRAL_BOUND    = 3'd5
   } csr_index_type;

endpackage

// ===== hw/rtl/pi_controller_with_integral_reset.sv =====
// An accepted update transaction passes through the stage registers into the response register.
// Throughput: one transaction per cycle unless stalled; the error, derivative and
// integral state is updated in a single stage, so each transaction sees the state
// left by the one before. Clear transactions update the state and give no response.
// Reset (synchronous) empties the pipeline, zeroes the controller state and reloads
// every configuration register with its reset value.
module pi_controller_with_integral_reset #(
   parameter int INTEGRAL_WIDTH = picir_pkg::INTEGRAL_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_opcode,
   input  logic signed [picir_pkg::ANGLE_W-1:0]      req_measured_angle,
   input  logic signed [picir_pkg::ANGLE_W-1:0]      req_target_angle,

   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [picir_pkg::DRIVE_W-1:0]      rsp_drive_value,
   output logic                                      rsp_rejected,
   output logic                                      rsp_saturated,

   input  logic                                      csr_write_enable,
   input  logic [picir_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [picir_pkg::CSR_DATA_W-1:0]          csr_write_data
);

   import picir_pkg::*;

   localparam int IW   = INTEGRAL_WIDTH;
   localparam int HI_W = IW - LO_W;
   localparam int IP_W = (IW + GAIN_W > CAP_W) ? IW + GAIN_W : CAP_W;

   localparam logic signed [IW-1:0]    INT_MAX     = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0]    INT_MIN     = {1'b1, {(IW-1){1'b0}}};
   localparam logic [CAP_W-1:0]        PRODUCT_CAP = {1'b1, {(CAP_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(1) << (SUM_FRAC - 1);
   localparam logic signed [SUM_W-1:0] TRUNC_BIAS  = (SUM_W'(1) << SUM_FRAC) - SUM_W'(1);

   // Configuration registers.
   logic [GAIN_W-1:0]   prop_gain_ff;
   logic [GAIN_W-1:0]   int_gain_ff;
   logic [GAIN_W-1:0]   deriv_gain_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [THRESH_W-1:0] thresh_ff;
   logic [THRESH_W-1:0] bound_ff;

   // Controller state.
   logic signed [ERR_W-1:0] prev_error_ff;
   logic signed [ERR_W-1:0] prev_error_in;
   logic signed [IW-1:0]    integral_ff;
   logic signed [IW-1:0]    integral_in;

   // Pipeline control.
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] take;
   logic [NUM_STAGES-1:0] free;

   // Stage 0: input register.
   opcode_type              s0_opcode_ff;
   logic signed [ANGLE_W-1:0] s0_measured_ff;
   logic signed [ANGLE_W-1:0] s0_target_ff;

   // Stage 1: error, derivative and updated integral.
   logic signed [ERR_W:0]   err_wide;
   logic [ERR_W:0]          err_mag_wide;
   logic                    reject;
   logic signed [ERR_W-1:0] err_val;
   logic signed [ERR_W:0]   deriv_val;
   logic signed [IW:0]      int_sum;
   logic signed [IW-1:0]    int_sat;
   logic signed [IW-1:0]    bound_s;
   logic                    err_pos;
   logic                    err_neg;
   logic signed [IW-1:0]    int_new;

   logic                    s1_rejected_ff;
   logic signed [ERR_W-1:0] s1_error_ff;
   logic signed [ERR_W:0]   s1_deriv_ff;
   logic signed [IW-1:0]    s1_integral_ff;

   // Stage 2: magnitudes and products.
   logic [ERR_W-1:0] err_mag;
   logic [ERR_W:0]   deriv_mag;
   logic [IW-1:0]    int_mag;

   logic                       s2_rejected_ff;
   logic                       s2_err_neg_ff;
   logic                       s2_deriv_neg_ff;
   logic                       s2_int_neg_ff;
   logic [ERR_W+GAIN_W-1:0]    s2_prop_prod_ff;
   logic [ERR_W+GAIN_W:0]      s2_deriv_prod_ff;
   logic [LO_W+GAIN_W-1:0]     s2_int_lo_ff;
   logic [HI_W+GAIN_W-1:0]     s2_int_hi_ff;

   // Stage 3: integral product assembled and capped, other terms signed.
   logic [IP_W-1:0]          int_full;
   logic [CAP_W-1:0]         int_capped;
   logic signed [SUM_W-1:0]  prop_term;
   logic signed [SUM_W-1:0]  deriv_term;

   logic                     s3_rejected_ff;
   logic                     s3_int_neg_ff;
   logic [CAP_W-1:0]         s3_int_mag_ff;
   logic signed [SUM_W-1:0]  s3_partial_ff;

   // Stage 4: full sum.
   logic signed [SUM_W-1:0]  int_term;
   logic                     s4_rejected_ff;
   logic signed [SUM_W-1:0]  s4_sum_ff;

   // Stage 5: clamp into the response register.
   logic signed [SUM_W-1:0]   lim;
   logic signed [SUM_W-1:0]   shifted;
   logic signed [DRIVE_W-1:0] drive_in;
   logic                      sat_in;
   logic signed [DRIVE_W-1:0] rsp_drive_value_ff;
   logic                      rsp_rejected_ff;
   logic                      rsp_saturated_ff;

   // ---------------------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROPORTIONAL_GAIN_RESET;
         int_gain_ff   <= INTEGRAL_GAIN_RESET;
         deriv_gain_ff <= DERIVATIVE_GAIN_RESET;
         limit_ff      <= OUTPUT_LIMIT_RESET;
         thresh_ff     <= REJECT_THRESHOLD_RESET;
         bound_ff      <= INTEGRAL_BOUND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_PROPORTIONAL_GAIN: prop_gain_ff  <= csr_write_data[GAIN_W-1:0];
            REG_INTEGRAL_GAIN:     int_gain_ff   <= csr_write_data[GAIN_W-1:0];
            REG_DERIVATIVE_GAIN:   deriv_gain_ff <= csr_write_data[GAIN_W-1:0];
            REG_OUTPUT_LIMIT:      limit_ff      <= csr_write_data[LIMIT_W-1:0];
            REG_REJECT_THRESHOLD:  thresh_ff     <= csr_write_data[THRESH_W-1:0];
            REG_INTEGRAL_BOUND:    bound_ff      <= csr_write_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Pipeline flow control: a stage moves on when the next one is empty or moving.
   // ---------------------------------------------------------------------------------
   always_comb begin
      take[NUM_STAGES-1] = valid_ff[NUM_STAGES-1] && !rsp_stall;
      free[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || take[NUM_STAGES-1];
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         take[i] = valid_ff[i] && free[i+1];
         free[i] = !valid_ff[i] || take[i];
      end
   end

   always_comb begin
      valid_in[0] = (req_valid && free[0]) || (valid_ff[0] && !take[0]);
      // A clear transaction ends in stage 0 once it has acted on the state.
      valid_in[1] = (take[0] && (s0_opcode_ff == OP_UPDATE)) || (valid_ff[1] && !take[1]);
      for (int i = 2; i < NUM_STAGES; i++) begin
         valid_in[i] = take[i-1] || (valid_ff[i] && !take[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !free[0];

   // ---------------------------------------------------------------------------------
   // Stage 0
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && free[0]) begin
         s0_opcode_ff   <= opcode_type'(req_opcode);
         s0_measured_ff <= req_measured_angle;
         s0_target_ff   <= req_target_angle;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: the state update happens as the transaction leaves stage 0.
   // ---------------------------------------------------------------------------------
   always_comb begin
      err_wide     = $signed({s0_measured_ff[ANGLE_W-1], s0_measured_ff})
                   - $signed({s0_target_ff[ANGLE_W-1], s0_target_ff});
      err_mag_wide = err_wide[ERR_W] ? ((ERR_W+1)'(0) - err_wide) : err_wide;
      reject       = err_mag_wide > {2'b00, thresh_ff};

      // Below the threshold the error always fits the stored width.
      err_val   = err_wide[ERR_W-1:0];
      deriv_val = $signed({err_val[ERR_W-1], err_val})
                - $signed({prev_error_ff[ERR_W-1], prev_error_ff});

      int_sum = $signed({integral_ff[IW-1], integral_ff})
              + $signed({{(IW+1-ERR_W){err_val[ERR_W-1]}}, err_val});
      if (int_sum[IW] != int_sum[IW-1]) begin
         int_sat = int_sum[IW] ? INT_MIN : INT_MAX;
      end else begin
         int_sat = int_sum[IW-1:0];
      end

      bound_s = $signed({{(IW-THRESH_W){1'b0}}, bound_ff});
      err_pos = !err_val[ERR_W-1] && (err_val != '0);
      err_neg = err_val[ERR_W-1];

      // An integral wound up against the error's direction is dropped.
      if (((int_sat < -bound_s) && err_pos) || ((int_sat > bound_s) && err_neg)) begin
         int_new = '0;
      end else begin
         int_new = int_sat;
      end
   end

   always_comb begin
      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      if (take[0]) begin
         if (s0_opcode_ff == OP_CLEAR) begin
            prev_error_in = '0;
            integral_in   = '0;
         end else if (!reject) begin
            prev_error_in = err_val;
            integral_in   = int_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
      end else begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take[0]) begin
         s1_rejected_ff <= reject;
         s1_error_ff    <= err_val;
         s1_deriv_ff    <= deriv_val;
         s1_integral_ff <= int_new;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 2: sign and magnitude, then the gain products.
   // ---------------------------------------------------------------------------------
   always_comb begin
      err_mag   = s1_error_ff[ERR_W-1] ? (ERR_W'(0) - s1_error_ff) : s1_error_ff;
      deriv_mag = s1_deriv_ff[ERR_W] ? ((ERR_W+1)'(0) - s1_deriv_ff) : s1_deriv_ff;
      int_mag   = s1_integral_ff[IW-1] ? (IW'(0) - s1_integral_ff) : s1_integral_ff;
   end

   always_ff @(posedge clock) begin
      if (take[1]) begin
         s2_rejected_ff   <= s1_rejected_ff;
         s2_err_neg_ff    <= s1_error_ff[ERR_W-1];
         s2_deriv_neg_ff  <= s1_deriv_ff[ERR_W];
         s2_int_neg_ff    <= s1_integral_ff[IW-1];
         s2_prop_prod_ff  <= err_mag * prop_gain_ff;
         s2_deriv_prod_ff <= deriv_mag * deriv_gain_ff;
         s2_int_lo_ff     <= int_mag[LO_W-1:0] * int_gain_ff;
         s2_int_hi_ff     <= int_mag[IW-1:LO_W] * int_gain_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 3
   // ---------------------------------------------------------------------------------
   always_comb begin
      int_full = (IP_W'(s2_int_hi_ff) << LO_W) + IP_W'(s2_int_lo_ff);
      if (int_full > IP_W'(PRODUCT_CAP)) begin
         int_capped = PRODUCT_CAP;
      end else begin
         int_capped = int_full[CAP_W-1:0];
      end

      prop_term  = s2_err_neg_ff ? -$signed(SUM_W'(s2_prop_prod_ff))
                                 :  $signed(SUM_W'(s2_prop_prod_ff));
      deriv_term = s2_deriv_neg_ff ? -$signed(SUM_W'(s2_deriv_prod_ff))
                                   :  $signed(SUM_W'(s2_deriv_prod_ff));
   end

   always_ff @(posedge clock) begin
      if (take[2]) begin
         s3_rejected_ff <= s2_rejected_ff;
         s3_int_neg_ff  <= s2_int_neg_ff;
         s3_int_mag_ff  <= int_capped;
         s3_partial_ff  <= prop_term + deriv_term + ROUND_HALF;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 4
   // ---------------------------------------------------------------------------------
   assign int_term = s3_int_neg_ff ? -$signed(SUM_W'(s3_int_mag_ff))
                                   :  $signed(SUM_W'(s3_int_mag_ff));

   always_ff @(posedge clock) begin
      if (take[3]) begin
         s4_rejected_ff <= s3_rejected_ff;
         s4_sum_ff      <= s3_partial_ff + int_term;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 5: zero a rejected result, else clamp, or truncate toward zero.
   // ---------------------------------------------------------------------------------
   always_comb begin
      lim     = $signed(SUM_W'(limit_ff) << SUM_FRAC);
      shifted = (s4_sum_ff + (s4_sum_ff[SUM_W-1] ? TRUNC_BIAS : SUM_W'(0))) >>> SUM_FRAC;
      if (s4_rejected_ff) begin
         drive_in = '0;
         sat_in   = 1'b0;
      end else if (s4_sum_ff > lim) begin
         drive_in = $signed({1'b0, limit_ff});
         sat_in   = 1'b1;
      end else if (s4_sum_ff < -lim) begin
         drive_in = -$signed({1'b0, limit_ff});
         sat_in   = 1'b1;
      end else begin
         drive_in = shifted[DRIVE_W-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take[4]) begin
         rsp_drive_value_ff <= drive_in;
         rsp_rejected_ff    <= s4_rejected_ff;
         rsp_saturated_ff   <= sat_in;
      end
   end

   assign rsp_valid       = valid_ff[NUM_STAGES-1];
   assign rsp_drive_value = rsp_drive_value_ff;
   assign rsp_rejected    = rsp_rejected_ff;
   assign rsp_saturated   = rsp_saturated_ff;

   // ---------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------
   a_stall_only_when_occupied: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[0]
   ) else $error("Input stalled with an empty input stage.");

   a_clear_zeroes_state: assert property (
      @(posedge clock) disable iff (reset)
      take[0] && (s0_opcode_ff == OP_CLEAR) |=> (prev_error_ff == '0) && (integral_ff == '0)
   ) else $error("Clear transaction did not zero the controller state.");

   a_reject_keeps_state: assert property (
      @(posedge clock) disable iff (reset)
      take[0] && (s0_opcode_ff == OP_UPDATE) && reject
         |=> $stable(prev_error_ff) && $stable(integral_ff)
   ) else $error("Rejected transaction altered the controller state.");

   a_reject_response: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> (rsp_drive_value == '0) && !rsp_saturated
   ) else $error("Rejected response carries a non-zero drive or a saturation flag.");

endmodule
